FILE: design/sljp_pkg.sv
// ----------------------------------------------------------------------------
// sljp_pkg
// Shared types, codes and widths for the start/length/XOR frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sljp_pkg;

    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h7E;
    localparam logic [BYTE_W-1:0] STOP_MARKER_RST  = 8'h7F;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_MARKER  = 1'd1;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_CMD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

    // frame status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADSTOP = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADXOR  = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] start_marker;
        logic [BYTE_W-1:0] stop_marker;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0]   item_kind;
        logic [BYTE_W-1:0]   out_byte;
        logic [STATUS_W-1:0] frame_status;
        logic [BYTE_W-1:0]   data_count;
    } result_t;

endpackage

`default_nettype wire

FILE: design/start_length_xor_frame_parser_top.sv
// ----------------------------------------------------------------------------
// start_length_xor_frame_parser_top
// Streams command and data bytes out of start/length/XOR/stop framed input
// and reports one status transaction per frame.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   s_axis    in         s_tvalid / s_tready  s_tdata[7:0] = in_byte
//   m_axis    out        m_tvalid / m_tready  m_tdata = out_byte, frame_status,
//                                             data_count; m_tuser = item_kind
//   cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Rate: one input transaction per clock while m_tready is high; a byte
//   passes through the input register, the frame state machine and the
//   result register, and its result is on m_tdata once both registers have
//   taken it.
// Reset: rst_n clears the markers to 0x7E / 0x7F and puts the parser in hunt.
// Stalls: when m_tready is low a waiting result holds in the result register
//   and the input register takes a byte only while empty; then s_tready drops.
// cfg_ready is always high; markers should be changed only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module start_length_xor_frame_parser_top
    import sljp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // input byte stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] in_byte
    // result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // [7:0] out_byte,
                                                   // [9:8] frame_status,
                                                   // [17:10] data_count,
                                                   // [23:18] zero
    output logic [KIND_W-1:0]           m_tuser,   // [1:0] item_kind
    // configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index, // 0 start_marker, 1 stop_marker
    input  wire logic [BYTE_W-1:0]      cfg_data
);

    cfg_t              cfg;
    logic              q_valid;
    logic              q_ready;
    logic [BYTE_W-1:0] q_byte;
    result_t           item;

    sljp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register slice
    sljp_in_stage u_in (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_byte  (s_tdata[7:0]),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_byte  (q_byte)
    );

    // frame state machine and result register
    sljp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_byte   (q_byte),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (item)
    );

    assign m_tdata = {6'd0, item.data_count, item.frame_status, item.out_byte};
    assign m_tuser = item.item_kind;

endmodule

`default_nettype wire

FILE: design/sljp_cfg_regs.sv
// ----------------------------------------------------------------------------
// sljp_cfg_regs
// Marker registers written over the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sljp_cfg_regs
    import sljp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_marker <= START_MARKER_RST;
            cfg_reg.stop_marker  <= STOP_MARKER_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_START_MARKER: cfg_reg.start_marker <= cfg_data;
                CFG_STOP_MARKER:  cfg_reg.stop_marker  <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: design/sljp_in_stage.sv
// ----------------------------------------------------------------------------
// sljp_in_stage
// Input register slice holding one received byte for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module sljp_in_stage
    import sljp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [BYTE_W-1:0] s_byte,
    output logic                   q_valid,
    input  wire logic              q_ready,
    output logic [BYTE_W-1:0]      q_byte
);

    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;

    assign s_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_byte  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_ready)
        begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            byte_reg <= s_byte;
        end
    end

endmodule

`default_nettype wire

FILE: design/sljp_parser.sv
// ----------------------------------------------------------------------------
// sljp_parser
// Frame state machine with its result register; one byte per cycle unless a waiting result stalls it.
// ----------------------------------------------------------------------------
`default_nettype none

module sljp_parser
    import sljp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [BYTE_W-1:0] in_byte,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output result_t                out_item
);

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_LEN   = 3'd1,
        PH_CMD   = 3'd2,
        PH_DATA  = 3'd3,
        PH_CHECK = 3'd4,
        PH_STOP  = 3'd5
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] length_reg, length_next;
    logic [BYTE_W-1:0] left_reg, left_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic [BYTE_W-1:0] check_reg, check_next;
    logic              out_valid_reg;
    result_t           item_reg, item_next;
    logic              emit;
    logic              step;
    logic [BYTE_W-1:0] left_dec;

    assign in_ready  = !out_valid_reg || out_ready;
    assign step      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = item_reg;
    assign left_dec  = left_reg - 8'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        left_next   = left_reg;
        xor_next    = xor_reg;
        check_next  = check_reg;
        emit        = 1'b0;
        item_next   = '0;
        unique case (phase_reg)
            PH_LEN:
            begin
                length_next = in_byte;
                xor_next    = in_byte;
                if (in_byte == '0)
                begin
                    left_next  = '0;
                    phase_next = PH_CHECK;
                end
                else
                begin
                    left_next  = in_byte - 8'd1;
                    phase_next = PH_CMD;
                end
            end
            PH_CMD:
            begin
                xor_next           = xor_reg ^ in_byte;
                phase_next         = (left_reg != '0) ? PH_DATA : PH_CHECK;
                emit               = 1'b1;
                item_next.item_kind = KIND_CMD;
                item_next.out_byte  = in_byte;
            end
            PH_DATA:
            begin
                xor_next  = xor_reg ^ in_byte;
                left_next = left_dec;
                if (left_dec == '0)
                begin
                    phase_next = PH_CHECK;
                end
                emit                = 1'b1;
                item_next.item_kind = KIND_DATA;
                item_next.out_byte  = in_byte;
            end
            PH_CHECK:
            begin
                check_next = in_byte;
                phase_next = PH_STOP;
            end
            PH_STOP:
            begin
                phase_next          = PH_HUNT;
                emit                = 1'b1;
                item_next.item_kind = KIND_STATUS;
                if (length_reg == '0)
                begin
                    item_next.frame_status = ST_SHORT;
                end
                else
                begin
                    item_next.data_count = length_reg - 8'd1;
                    if (in_byte != cfg.stop_marker)
                    begin
                        item_next.frame_status = ST_BADSTOP;
                    end
                    else if (check_reg != xor_reg)
                    begin
                        item_next.frame_status = ST_BADXOR;
                    end
                    else
                    begin
                        item_next.frame_status = ST_OK;
                    end
                end
            end
            default:
            begin
                // hunting; unused phase codes land here too
                if (in_byte == cfg.start_marker)
                begin
                    phase_next  = PH_LEN;
                    length_next = '0;
                    left_next   = '0;
                    xor_next    = '0;
                    check_next  = '0;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            length_reg    <= '0;
            left_reg      <= '0;
            xor_reg       <= '0;
            check_reg     <= '0;
            out_valid_reg <= 1'b0;
            item_reg      <= '0;
        end
        else
        begin
            if (step)
            begin
                phase_reg  <= phase_next;
                length_reg <= length_next;
                left_reg   <= left_next;
                xor_reg    <= xor_next;
                check_reg  <= check_next;
            end
            if (step && emit)
            begin
                out_valid_reg <= 1'b1;
                item_reg      <= item_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // a command byte always yields a command result on the next cycle
    a_cmd_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_CMD) |=>
            (out_valid_reg && item_reg.item_kind == KIND_CMD))
        else $error("command byte did not produce a command result");

    // the stop byte always returns the parser to hunting
    a_stop_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_STOP) |=> (phase_reg == PH_HUNT))
        else $error("parser did not return to hunting after stop byte");

    // byte results carry no status or count
    a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && item_reg.item_kind != KIND_STATUS) |->
            (item_reg.frame_status == ST_OK && item_reg.data_count == '0))
        else $error("byte result carries status fields");

    // status results carry a zero byte
    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && item_reg.item_kind == KIND_STATUS) |->
            (item_reg.out_byte == '0))
        else $error("status result carries a nonzero byte");

endmodule

`default_nettype wire

FILE: dv/start_length_xor_frame_parser_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// start_length_xor_frame_parser_top_tb
// Self-checking bench for the start/length/XOR/stop frame parser. Sends byte
// streams of whole, damaged and cut frames plus line noise, predicts every
// command, data and status transaction in step with the input handshakes, and
// compares each output transaction field by field in arrival order.
// ----------------------------------------------------------------------------

module start_length_xor_frame_parser_top_tb;
    import sljp_pkg::*;

    // Generous ceiling on the run length.
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    // Bytes that make no result can still sit in the two-stage pipe.
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned REPORT_CAP    = 100;

    // Parser position within a frame.
    typedef enum logic [2:0] {
        P_HUNT, P_LEN, P_CMD, P_DATA, P_CHECK, P_STOP
    } frame_phase_t;

    // Ways a generated frame can be damaged.
    typedef enum int {
        FAULT_NONE, FAULT_XOR, FAULT_STOP, FAULT_BOTH, FAULT_CUT
    } frame_fault_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]      m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [BYTE_W-1:0]      cfg_data  = '0;

    start_length_xor_frame_parser_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predicted parser state. Only the observer process below writes it, at
    // the clock edge where a transaction is seen.
    // ------------------------------------------------------------------------
    logic [BYTE_W-1:0] cur_start  = START_MARKER_RST;
    logic [BYTE_W-1:0] cur_stop   = STOP_MARKER_RST;
    frame_phase_t      frm_phase  = P_HUNT;
    logic [BYTE_W-1:0] frm_length = '0;
    logic [BYTE_W-1:0] frm_left   = '0;
    logic [BYTE_W-1:0] frm_xor    = '0;
    logic [BYTE_W-1:0] frm_check  = '0;

    result_t pending_results[$];

    // Markers the stimulus side frames with; kept apart from the predicted
    // copy so that frame building never races the observer.
    logic [BYTE_W-1:0] gen_start = START_MARKER_RST;
    logic [BYTE_W-1:0] gen_stop  = STOP_MARKER_RST;

    // Idling controls, switched per test.
    bit tx_gap_en   = 1'b0;
    bit rx_stall_en = 1'b0;

    // Bookkeeping.
    int unsigned cycle_count     = 0;
    int unsigned mismatch_count  = 0;
    int unsigned results_checked = 0;
    int unsigned bytes_sent      = 0;
    int unsigned frame_bytes     = 0;
    int unsigned frames_sent     = 0;
    int unsigned settings_used   = 0;
    int unsigned status_hits[4]  = '{default: 0};

    // Idle length: mostly none, often short, now and then long.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // ------------------------------------------------------------------------
    // Frame parser prediction for one accepted byte.
    // ------------------------------------------------------------------------
    task automatic parse_byte(input logic [BYTE_W-1:0] b);
        result_t r;
        bit      has_result;
        r          = '0;
        has_result = 1'b0;
        case (frm_phase)
            P_LEN:
            begin
                frm_length = b;
                frm_xor    = b;
                if (b == 8'd0)
                begin
                    // zero length: next two bytes are checksum and stop
                    frm_left  = '0;
                    frm_phase = P_CHECK;
                end
                else
                begin
                    frm_left  = b - 8'd1;
                    frm_phase = P_CMD;
                end
            end
            P_CMD:
            begin
                frm_xor      = frm_xor ^ b;
                frm_phase    = (frm_left != 8'd0) ? P_DATA : P_CHECK;
                r.item_kind  = KIND_CMD;
                r.out_byte   = b;
                has_result   = 1'b1;
            end
            P_DATA:
            begin
                frm_xor  = frm_xor ^ b;
                frm_left = frm_left - 8'd1;
                if (frm_left == 8'd0)
                    frm_phase = P_CHECK;
                r.item_kind = KIND_DATA;
                r.out_byte  = b;
                has_result  = 1'b1;
            end
            P_CHECK:
            begin
                frm_check = b;
                frm_phase = P_STOP;
            end
            P_STOP:
            begin
                frm_phase   = P_HUNT;
                r.item_kind = KIND_STATUS;
                // too short beats bad stop, which beats bad checksum
                if (frm_length == 8'd0)
                    r.frame_status = ST_SHORT;
                else
                begin
                    r.data_count = frm_length - 8'd1;
                    if (b != cur_stop)
                        r.frame_status = ST_BADSTOP;
                    else if (frm_check != frm_xor)
                        r.frame_status = ST_BADXOR;
                    else
                        r.frame_status = ST_OK;
                end
                has_result = 1'b1;
            end
            default:
            begin
                if (b == cur_start)
                begin
                    frm_phase  = P_LEN;
                    frm_length = '0;
                    frm_left   = '0;
                    frm_xor    = '0;
                    frm_check  = '0;
                end
                else
                    frm_phase = P_HUNT;
            end
        endcase
        if (has_result)
            pending_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
            $display("%0t ns: result %0d, %s got 0x%0h, expected 0x%0h",
                     $time, results_checked, what, got, want);
    endtask

    // Compare one output transaction against the oldest prediction.
    task automatic check_result();
        result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("result with nothing pending, tdata", 32'(m_tdata), 32'd0);
            return;
        end
        want = pending_results.pop_front();
        if (m_tuser !== want.item_kind)
            report_mismatch("item_kind", 32'(m_tuser), 32'(want.item_kind));
        if (m_tdata[7:0] !== want.out_byte)
            report_mismatch("out_byte", 32'(m_tdata[7:0]), 32'(want.out_byte));
        if (m_tdata[9:8] !== want.frame_status)
            report_mismatch("frame_status", 32'(m_tdata[9:8]),
                            32'(want.frame_status));
        if (m_tdata[17:10] !== want.data_count)
            report_mismatch("data_count", 32'(m_tdata[17:10]),
                            32'(want.data_count));
        if (m_tdata[23:18] !== '0)
            report_mismatch("tdata padding", 32'(m_tdata[23:18]), 32'd0);
        if (want.item_kind == KIND_STATUS)
            status_hits[want.frame_status]++;
        results_checked++;
    endtask

    // ------------------------------------------------------------------------
    // Observer: register writes, input bytes and results, all sampled at the
    // rising edge. Prediction comes first so a same-edge result still finds
    // its expectation.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_START_MARKER: cur_start = cfg_data;
                    CFG_STOP_MARKER:  cur_stop  = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                parse_byte(s_tdata);
            if (m_tvalid && m_tready)
                check_result();
        end
    end

    // Result side back-pressure: ready runs broken by stalls of random length.
    int unsigned ready_hold = 0;

    always @(posedge clk)
    begin
        if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else if (!rx_stall_en)
            m_tready <= 1'b1;
        else if (m_tready)
        begin
            m_tready   <= 1'b0;
            ready_hold <= gap_len();
        end
        else
        begin
            m_tready   <= 1'b1;
            ready_hold <= $urandom_range(0, 15);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_results.size());
            $display("start_length_xor_frame_parser_top: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus primitives. Each returns right after the edge that completed
    // its transaction and leaves tvalid as it is, so back-to-back bytes keep
    // tvalid high without a same-step low/high pair.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int unsigned gap;
        gap = tx_gap_en ? gap_len() : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
    endtask

    // Start, length, command, length-1 data bytes, checksum, stop; damaged
    // as asked. A cut frame stops early and the next bytes land inside it.
    task automatic send_frame(input int unsigned len, input frame_fault_t fault);
        logic [BYTE_W-1:0] frame[$];
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] b;
        int unsigned       n;
        frame.push_back(gen_start);
        frame.push_back(len[7:0]);
        x = len[7:0];
        repeat (len)
        begin
            b = 8'($urandom);
            x = x ^ b;
            frame.push_back(b);
        end
        if (fault == FAULT_XOR || fault == FAULT_BOTH)
            x = x ^ 8'($urandom_range(1, 255));
        frame.push_back(x);
        if (fault == FAULT_STOP || fault == FAULT_BOTH)
            frame.push_back(gen_stop ^ 8'($urandom_range(1, 255)));
        else
            frame.push_back(gen_stop);
        n = (fault == FAULT_CUT) ? $urandom_range(1, len + 3) : frame.size();
        for (int unsigned i = 0; i < n; i++)
            send_byte(frame[i]);
        frame_bytes += n;
        frames_sent++;
    endtask

    // Line noise between frames; it stays clear of the start marker so the
    // following frame is parsed as sent.
    task automatic send_noise(input int unsigned n);
        logic [BYTE_W-1:0] b;
        repeat (n)
        begin
            b = 8'($urandom);
            if (b == gen_start)
                b = ~b;
            send_byte(b);
        end
    endtask

    // Stop sending and wait until every predicted result has come out.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // cfg_valid stays high across back-to-back writes; the caller drops it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [BYTE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic set_markers(input logic [BYTE_W-1:0] start_value,
                               input logic [BYTE_W-1:0] stop_value);
        wait_idle();
        write_reg(CFG_START_MARKER, start_value);
        write_reg(CFG_STOP_MARKER, stop_value);
        cfg_valid <= 1'b0;
        gen_start = start_value;
        gen_stop  = stop_value;
        settings_used++;
    endtask

    // Mostly good frames with random content and small lengths, some
    // damaged or cut, a rare long one, with noise in between.
    task automatic run_random(input int unsigned n_bytes);
        int unsigned  stop_at;
        int unsigned  r;
        int unsigned  len;
        frame_fault_t fault;
        stop_at = frame_bytes + n_bytes;
        while (frame_bytes < stop_at)
        begin
            if ($urandom_range(0, 9) == 0)
                send_noise($urandom_range(1, 4));
            r = $urandom_range(0, 99);
            if (r < 8)
                len = 0;
            else if (r < 9)
                len = $urandom_range(60, 255);
            else
                len = $urandom_range(1, 10);
            r = $urandom_range(0, 99);
            if (r < 70)
                fault = FAULT_NONE;
            else if (r < 80)
                fault = FAULT_XOR;
            else if (r < 87)
                fault = FAULT_STOP;
            else if (r < 92)
                fault = FAULT_BOTH;
            else
                fault = FAULT_CUT;
            send_frame(len, fault);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-built frames on the reset markers, no idling.
    task automatic test_directed_cases();
        tx_gap_en   = 1'b0;
        rx_stall_en = 1'b0;
        // noise at both byte extremes, then a zero-length frame whose stop
        // byte is also wrong: too short must win
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(START_MARKER_RST);
        send_byte(8'h00);
        send_byte(8'h55);
        send_byte(8'h00);
        // command only, all ones
        send_byte(START_MARKER_RST);
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'h01 ^ 8'hFF);
        send_byte(STOP_MARKER_RST);
        // both markers as payload, wrong checksum and wrong stop:
        // bad stop must win over the checksum
        send_byte(START_MARKER_RST);
        send_byte(8'h03);
        send_byte(START_MARKER_RST);
        send_byte(STOP_MARKER_RST);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(START_MARKER_RST);
        // right stop, checksum off by one bit
        send_byte(START_MARKER_RST);
        send_byte(8'h02);
        send_byte(8'h10);
        send_byte(8'h20);
        send_byte(8'h02 ^ 8'h10 ^ 8'h20 ^ 8'h01);
        send_byte(STOP_MARKER_RST);
    endtask

    // Reset markers; a stretch at full rate, then with idling on both sides.
    task automatic test_random_default_markers();
        tx_gap_en   = 1'b0;
        rx_stall_en = 1'b0;
        run_random(150);
        tx_gap_en   = 1'b1;
        rx_stall_en = 1'b1;
        run_random(150);
    endtask

    // Marker extremes, swapped, random, equal, and back to reset values.
    task automatic test_marker_settings();
        logic [BYTE_W-1:0] same;
        same        = 8'($urandom);
        tx_gap_en   = 1'b1;
        rx_stall_en = 1'b1;
        set_markers(8'h00, 8'hFF);
        run_random(180);
        set_markers(8'hFF, 8'h00);
        run_random(180);
        set_markers(8'($urandom), 8'($urandom));
        run_random(180);
        // start and stop share one value
        set_markers(same, same);
        run_random(180);
        set_markers(START_MARKER_RST, STOP_MARKER_RST);
        run_random(100);
    endtask

    // Longest length byte: 254 data bytes, good and with a bad checksum.
    task automatic test_longest_frames();
        tx_gap_en   = 1'b1;
        rx_stall_en = 1'b1;
        send_frame(255, FAULT_NONE);
        send_frame(255, FAULT_XOR);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_default_markers();
        test_marker_settings();
        test_longest_frames();

        wait_idle();

        $display("sent %0d bytes in %0d frames over %0d marker settings; %0d results checked",
                 bytes_sent, frames_sent, settings_used + 1, results_checked);
        $display("frame status seen: ok %0d, too short %0d, bad stop %0d, bad checksum %0d",
                 status_hits[ST_OK], status_hits[ST_SHORT],
                 status_hits[ST_BADSTOP], status_hits[ST_BADXOR]);
        if (mismatch_count == 0)
            $display("start_length_xor_frame_parser_top: match");
        else
            $display("start_length_xor_frame_parser_top: mismatch");
        $finish;
    end

endmodule

FILE: files.f
design/sljp_pkg.sv
design/sljp_cfg_regs.sv
design/sljp_in_stage.sv
design/sljp_parser.sv
design/start_length_xor_frame_parser_top.sv
dv/start_length_xor_frame_parser_top_tb.sv
